// ===== design/pawq_pkg.sv =====
// ----------------------------------------------------------------------------
// pawq_pkg
// Shared types and constants of the port allocator with timed quarantine.
// ----------------------------------------------------------------------------
package pawq_pkg;

	// sizing
	localparam int PORT_COUNT      = 65536;
	localparam int FIRST_EPHEMERAL = 64512;
	localparam int LAST_EPHEMERAL  = 65535;
	localparam int QUEUE_DEPTH     = 1024;

	// bitmap rows: one row holds in-use and listener bits of WORD_BITS ports
	localparam int WORD_BITS = 16;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int MAP_ROWS  = PORT_COUNT / WORD_BITS;
	localparam int MAP_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
	localparam int MAP_DW    = 2 * WORD_BITS;

	// quarantine fifo
	localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int QSUM_W = QC_W + 1;
	localparam int QDW    = 16 + 32;

	// clipped ephemeral range
	localparam int LO_PORT = FIRST_EPHEMERAL;
	localparam int HI_PORT = (LAST_EPHEMERAL > PORT_COUNT - 1) ? PORT_COUNT - 1
		: LAST_EPHEMERAL;
	localparam bit RANGE_EMPTY = (LO_PORT > HI_PORT);
	localparam logic [MAP_AW-1:0] LO_ROW = MAP_AW'(LO_PORT / WORD_BITS);
	localparam logic [MAP_AW-1:0] HI_ROW = MAP_AW'(HI_PORT / WORD_BITS);
	localparam logic [BIT_W-1:0]  LO_BIT = BIT_W'(LO_PORT % WORD_BITS);
	localparam logic [BIT_W-1:0]  HI_BIT = BIT_W'(HI_PORT % WORD_BITS);

	// action codes
	localparam logic [2:0] ACT_ALLOC    = 3'd0;
	localparam logic [2:0] ACT_FREE     = 3'd1;
	localparam logic [2:0] ACT_LISTEN   = 3'd2;
	localparam logic [2:0] ACT_UNLISTEN = 3'd3;
	localparam logic [2:0] ACT_SHUTDOWN = 3'd4;
	localparam logic [2:0] ACT_TICK     = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BOUND = 2'd1;
	localparam logic [1:0] ST_NORES = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [31:0] QT_RESET = 32'd1000;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] port;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] allocated_port;
	} rsp_t;

endpackage

// ===== design/pawq_ram.sv =====
// ----------------------------------------------------------------------------
// pawq_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module pawq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/port_allocator_with_quarantine.sv =====
// ----------------------------------------------------------------------------
// port_allocator_with_quarantine
// Port allocator over an in-use and listener bitmap, with a fifo that holds
// freed ports until their release tick.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  command   cmd (action, port)         taken when start & !busy
//  result    result (status, port)      shown for one cycle with done
//  config    cfg_wdata                  written when cfg_we
//
// allocate first drains every expired fifo entry, then scans bitmap rows of
// 16 ports from the low end of the range; the bitmap ram has one read port,
// so each row is read before it is checked or written.
// after reset a clearing pass writes every bitmap row, all MAP_ROWS (4096),
// with busy high; config writes are taken throughout.
// results cannot be stalled; one item is worked on at a time.
// ----------------------------------------------------------------------------
module port_allocator_with_quarantine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pawq_pkg::cmd_t cmd,
	output logic          done,
	output pawq_pkg::rsp_t result,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);
	import pawq_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_QCHK  = 4'd2;
	localparam logic [3:0] S_DRD   = 4'd3;
	localparam logic [3:0] S_DWR   = 4'd4;
	localparam logic [3:0] S_SRD   = 4'd5;
	localparam logic [3:0] S_SCHK  = 4'd6;
	localparam logic [3:0] S_PRD   = 4'd7;
	localparam logic [3:0] S_PEX   = 4'd8;
	localparam logic [3:0] S_TICK  = 4'd9;

	logic [3:0]        state_q;
	cmd_t              cmd_q;
	logic [31:0]       qt_q;
	logic [31:0]       tick_q;
	logic [QA_W-1:0]   head_q;
	logic [QC_W-1:0]   count_q;
	logic [MAP_AW-1:0] clr_q;
	logic [MAP_AW-1:0] scan_row_q;
	logic [15:0]       drain_port_q;
	logic              done_q;
	rsp_t              res_q;

	// memory ports
	logic              map_we;
	logic [MAP_AW-1:0] map_waddr;
	logic [MAP_DW-1:0] map_wdata;
	logic [MAP_AW-1:0] map_raddr;
	logic [MAP_DW-1:0] map_rdata;
	logic              q_we;
	logic [QA_W-1:0]   q_waddr;
	logic [QDW-1:0]    q_wdata;
	logic [QDW-1:0]    q_rdata;

	logic [MAP_AW-1:0]    port_row;
	logic [BIT_W-1:0]     port_bit;
	logic                 port_valid;
	logic [MAP_AW-1:0]    drain_row;
	logic [15:0]          q_head_port;
	logic [31:0]          q_head_rel;
	logic [32:0]          rel_sum;
	logic [31:0]          rel;
	logic [QSUM_W-1:0]    tail_sum;
	logic [QA_W-1:0]      tail;
	logic [WORD_BITS-1:0] use_bits;
	logic [WORD_BITS-1:0] lis_bits;
	logic [WORD_BITS-1:0] free_bits;
	logic                 found;
	logic [BIT_W-1:0]     pick;

	pawq_ram #(.WIDTH(MAP_DW), .DEPTH(MAP_ROWS), .AW(MAP_AW)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);

	pawq_ram #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH), .AW(QA_W)) u_fifo (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(head_q), .rdata(q_rdata)
	);

	// address and field decode
	assign port_row    = MAP_AW'(cmd_q.port >> BIT_W);
	assign port_bit    = cmd_q.port[BIT_W-1:0];
	assign port_valid  = ({1'b0, cmd_q.port} < 17'(PORT_COUNT));
	assign drain_row   = MAP_AW'(drain_port_q >> BIT_W);
	assign q_head_port = q_rdata[QDW-1:32];
	assign q_head_rel  = q_rdata[31:0];
	assign use_bits    = map_rdata[WORD_BITS-1:0];
	assign lis_bits    = map_rdata[MAP_DW-1:WORD_BITS];

	// saturating release time and fifo tail
	assign rel_sum  = {1'b0, tick_q} + {1'b0, qt_q};
	assign rel      = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
	assign tail_sum = QSUM_W'(head_q) + QSUM_W'(count_q);
	assign tail     = (tail_sum >= QSUM_W'(QUEUE_DEPTH))
		? QA_W'(tail_sum - QSUM_W'(QUEUE_DEPTH)) : QA_W'(tail_sum);
	assign q_waddr  = tail;
	assign q_wdata  = {cmd_q.port, rel};

	// lowest clear port of the scanned row inside the range
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			free_bits[b] = !use_bits[b]
				&& !(scan_row_q == LO_ROW && BIT_W'(b) < LO_BIT)
				&& !(scan_row_q == HI_ROW && BIT_W'(b) > HI_BIT);
		end
		found = |free_bits;
		pick  = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				pick = BIT_W'(b);
			end
		end
	end

	// map read address
	always_comb begin
		case (state_q)
			S_DRD:   map_raddr = drain_row;
			S_SRD:   map_raddr = scan_row_q;
			default: map_raddr = port_row;
		endcase
	end

	// map write and fifo push
	always_comb begin
		map_we    = 1'b0;
		map_waddr = port_row;
		map_wdata = map_rdata;
		q_we      = 1'b0;
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_waddr = clr_q;
				map_wdata = '0;
			end
			S_DWR: begin
				map_we    = 1'b1;
				map_waddr = drain_row;
				map_wdata[drain_port_q[BIT_W-1:0]] = 1'b0;
			end
			S_SCHK: begin
				map_we    = found;
				map_waddr = scan_row_q;
				map_wdata[pick] = 1'b1;
			end
			S_PEX: begin
				case (cmd_q.action)
					ACT_LISTEN: begin
						map_we = port_valid && !use_bits[port_bit] && !lis_bits[port_bit];
						map_wdata[port_bit] = 1'b1;
						map_wdata[WORD_BITS + int'(port_bit)] = 1'b1;
					end
					ACT_UNLISTEN: begin
						map_we = port_valid;
						map_wdata[port_bit] = 1'b0;
						map_wdata[WORD_BITS + int'(port_bit)] = 1'b0;
					end
					ACT_FREE: begin
						q_we = port_valid && (count_q < QC_W'(QUEUE_DEPTH));
					end
					ACT_SHUTDOWN: begin
						q_we = port_valid && !lis_bits[port_bit]
							&& (count_q < QC_W'(QUEUE_DEPTH));
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qt_q <= QT_RESET;
		end else if (cfg_we) begin
			qt_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			tick_q     <= '0;
			head_q     <= '0;
			count_q    <= '0;
			done_q     <= 1'b0;
			scan_row_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						case (cmd.action)
							ACT_ALLOC: state_q <= S_QCHK;
							ACT_TICK:  state_q <= S_TICK;
							default:   state_q <= S_PRD;
						endcase
					end
				end
				S_TICK: begin
					if (cmd_q.action == ACT_TICK && tick_q != 32'hFFFF_FFFF) begin
						tick_q <= tick_q + 32'd1;
					end
					res_q   <= '{status: ST_OK, allocated_port: 16'd0};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QCHK: begin
					if (count_q != '0 && tick_q >= q_head_rel) begin
						drain_port_q <= q_head_port;
						head_q  <= (head_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_q <= count_q - 1'b1;
						state_q <= S_DRD;
					end else if (RANGE_EMPTY) begin
						res_q   <= '{status: ST_NORES, allocated_port: 16'd0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_row_q <= LO_ROW;
						state_q    <= S_SRD;
					end
				end
				S_DRD: state_q <= S_DWR;
				S_DWR: state_q <= S_QCHK;
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (found) begin
						res_q <= '{status: ST_OK,
							allocated_port: (16'(scan_row_q) << BIT_W) | 16'(pick)};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (scan_row_q == HI_ROW) begin
						res_q   <= '{status: ST_NORES, allocated_port: 16'd0};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_row_q <= scan_row_q + 1'b1;
						state_q    <= S_SRD;
					end
				end
				S_PRD: state_q <= S_PEX;
				S_PEX: begin
					res_q <= '{status: ST_OK, allocated_port: 16'd0};
					if (q_we) begin
						count_q <= count_q + 1'b1;
					end
					case (cmd_q.action)
						ACT_LISTEN: begin
							if (!port_valid || use_bits[port_bit] || lis_bits[port_bit]) begin
								res_q.status <= ST_BOUND;
							end
						end
						ACT_FREE: begin
							if (port_valid && count_q >= QC_W'(QUEUE_DEPTH)) begin
								res_q.status <= ST_FULL;
							end
						end
						ACT_SHUTDOWN: begin
							if (port_valid && !lis_bits[port_bit]
								&& count_q >= QC_W'(QUEUE_DEPTH)) begin
								res_q.status <= ST_FULL;
							end
						end
						default: begin
						end
					endcase
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while still busy");
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.allocated_port == 16'd0)
		else $error("failed item carries a port");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QC_W'(QUEUE_DEPTH)) else $error("fifo count beyond depth");
`endif

endmodule

// ===== tb/sv/pawq_checker.sv =====
// ----------------------------------------------------------------------------
// pawq_checker
// Watches the command, result and config channels of the port allocator,
// keeps its own copy of the bitmaps, quarantine fifo and tick counter, and
// compares every result with the one predicted for the oldest open item.
// ----------------------------------------------------------------------------
module pawq_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  pawq_pkg::cmd_t cmd,
	input  logic           done,
	input  pawq_pkg::rsp_t result,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_wdata,
	output int             fail_count,
	output int             open_items
);
	import pawq_pkg::*;

	bit          port_taken [PORT_COUNT];
	bit          port_listening [PORT_COUNT];
	logic [15:0] held_port [$];
	logic [31:0] held_until [$];
	logic [31:0] now_ticks;
	logic [31:0] hold_ticks;
	rsp_t        due_rsp [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// put a port into quarantine, release time saturating at the top
	function automatic logic [1:0] quarantine(input logic [15:0] p);
		logic [32:0] rel;
		if (held_port.size() >= QUEUE_DEPTH)
			return ST_FULL;
		rel = {1'b0, now_ticks} + {1'b0, hold_ticks};
		held_port.insert(held_port.size(), p);
		held_until.insert(held_until.size(), rel[32] ? 32'hFFFF_FFFF : rel[31:0]);
		return ST_OK;
	endfunction

	// work out the result of one command and update the model state
	function automatic rsp_t serve_command(input cmd_t c);
		rsp_t r;
		int   p;
		r = '0;
		case (c.action)
			ACT_ALLOC: begin
				while (held_port.size() > 0 && now_ticks >= held_until[0]) begin
					port_taken[held_port[0]] = 1'b0;
					held_port.delete(0);
					held_until.delete(0);
				end
				r.status = ST_NORES;
				if (!RANGE_EMPTY)
					for (p = LO_PORT; p <= HI_PORT; p++)
						if (!port_taken[p]) begin
							port_taken[p] = 1'b1;
							r.status = ST_OK;
							r.allocated_port = p[15:0];
							break;
						end
			end
			ACT_FREE: r.status = quarantine(c.port);
			ACT_LISTEN: begin
				if (port_taken[c.port] || port_listening[c.port])
					r.status = ST_BOUND;
				else begin
					port_taken[c.port] = 1'b1;
					port_listening[c.port] = 1'b1;
				end
			end
			ACT_UNLISTEN: begin
				port_taken[c.port] = 1'b0;
				port_listening[c.port] = 1'b0;
			end
			ACT_SHUTDOWN: if (!port_listening[c.port]) r.status = quarantine(c.port);
			ACT_TICK: if (now_ticks != 32'hFFFF_FFFF) now_ticks++;
			default: ;
		endcase
		return r;
	endfunction

	// compare results, predict accepted items, follow config writes
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			foreach (port_taken[i]) begin
				port_taken[i] = 1'b0;
				port_listening[i] = 1'b0;
			end
			held_port.delete();
			held_until.delete();
			due_rsp.delete();
			now_ticks = '0;
			hold_ticks = QT_RESET;
			fail_count = 0;
			open_items = 0;
		end else begin
			if (done) begin
				if (due_rsp.size() == 0)
					report_mismatch("result with no open item, status",
						32'(result.status), 32'd0);
				else begin
					want = due_rsp[0];
					due_rsp.delete(0);
					if (result.status !== want.status)
						report_mismatch("status", 32'(result.status), 32'(want.status));
					if (result.allocated_port !== want.allocated_port)
						report_mismatch("allocated_port", 32'(result.allocated_port),
							32'(want.allocated_port));
				end
			end
			if (start && !busy)
				due_rsp.insert(due_rsp.size(), serve_command(cmd));
			if (cfg_we)
				hold_ticks = cfg_wdata;
			open_items = due_rsp.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the port allocator with directed and random commands over several
// quarantine settings, fills the quarantine fifo past full to reach the
// queue-full case, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import pawq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	rsp_t        result;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	int          fail_count;
	int          open_items;
	int          gap_pct;

	port_allocator_with_quarantine DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	pawq_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .open_items(open_items)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hand one item over, then maybe leave a gap; called at a falling edge
	task automatic issue(input logic [2:0] act, input logic [15:0] p);
		start <= 1'b1;
		cmd <= '{action: act, port: p};
		do @(posedge clk); while (busy);
		@(negedge clk);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	// wait for every open item, then write the quarantine time
	task automatic set_hold(input logic [31:0] v);
		start <= 1'b0;
		while (open_items != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_port();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 16'(FIRST_EPHEMERAL + $urandom_range(0, 1023));
		if (r < 80) return 16'($urandom_range(0, 65535));
		if (r < 92) return 16'($urandom_range(0, 31));
		return (r < 96) ? 16'hFFFF : 16'h0000;
	endfunction

	task automatic random_items(input int n);
		int r;
		logic [2:0] act;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 25) act = ACT_ALLOC;
			else if (r < 45) act = ACT_FREE;
			else if (r < 60) act = ACT_LISTEN;
			else if (r < 70) act = ACT_UNLISTEN;
			else if (r < 80) act = ACT_SHUTDOWN;
			else if (r < 97) act = ACT_TICK;
			else act = 3'($urandom_range(6, 7));
			issue(act, pick_port());
		end
	endtask

	// timeout
	initial begin
		#100_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		gap_pct = 20;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero hold time, corner ports and every action
		set_hold(32'd0);
		issue(ACT_ALLOC, 16'd0);
		issue(ACT_ALLOC, 16'hFFFF);
		issue(ACT_LISTEN, 16'(FIRST_EPHEMERAL + 2));
		issue(ACT_LISTEN, 16'(FIRST_EPHEMERAL + 2));
		issue(ACT_LISTEN, 16'd0);
		issue(ACT_LISTEN, 16'hFFFF);
		issue(ACT_LISTEN, 16'hFFFF);
		issue(ACT_FREE, 16'(FIRST_EPHEMERAL));
		issue(ACT_ALLOC, 16'd0);
		issue(ACT_FREE, 16'd100);
		issue(ACT_SHUTDOWN, 16'd0);
		issue(ACT_SHUTDOWN, 16'(FIRST_EPHEMERAL + 1));
		issue(ACT_UNLISTEN, 16'd0);
		issue(ACT_UNLISTEN, 16'd5);
		issue(ACT_TICK, 16'h5555);
		issue(3'd6, 16'hAAAA);
		issue(3'd7, 16'hFFFF);
		issue(ACT_ALLOC, 16'd0);
		issue(ACT_TICK, 16'd0);
		issue(ACT_FREE, 16'hFFFF);
		issue(ACT_UNLISTEN, 16'hFFFF);
		issue(ACT_ALLOC, 16'd0);

		// random traffic with short hold times so the fifo drains often
		repeat (6) begin
			set_hold($urandom_range(1, 8));
			random_items(40);
		end

		// fill the quarantine fifo past full, then let it drain
		gap_pct = 51;
		set_hold(32'd2);
		repeat (1030) issue(($urandom_range(9) == 0) ? ACT_SHUTDOWN : ACT_FREE, pick_port());
		repeat (3) issue(ACT_TICK, 16'd0);
		repeat (60) issue(ACT_ALLOC, 16'($urandom_range(0, 65535)));
		random_items(40);

		// longest hold time: release saturates and ports freed here never leave the fifo
		gap_pct = 0;
		set_hold(32'hFFFF_FFFF);
		random_items(100);

		start <= 1'b0;
		while (open_items != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0 && open_items == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
